### rtl/median_by_selection_sort_core_macros.svh
// Assertion macros for the median core checker
`ifndef MEDIAN_BY_SELECTION_SORT_CORE_MACROS_SVH
`define MEDIAN_BY_SELECTION_SORT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("median core check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define MSS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("median core check failed");

`endif

### rtl/mss_pkg.sv
// Shared types of the median core: sorter state and control group
package mss_pkg;

	typedef enum logic [2:0] {
		SORT_IDLE,
		SORT_HEAD,
		SORT_SCAN,
		SORT_SWAP,
		SORT_DONE
	} sort_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} sort_ctl_t;

endpackage

### rtl/mss_if.sv
// Valid/ready stream interfaces for sample words and median words
interface mss_in_if #(parameter int DW = 24);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] sample;
	logic                 last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface mss_out_if #(parameter int DW = 24, parameter int CW = 11);
	logic               valid;
	logic               ready;
	logic signed [DW:0] median_x2;
	logic [CW-1:0]      sample_count;
	logic               overflowed;

	modport source (output valid, output median_x2, output sample_count, output overflowed,
		input ready);
	modport sink (input valid, input median_x2, input sample_count, input overflowed,
		output ready);
endinterface

### rtl/mss_mem.sv
// Sample store: one write port, one read port with registered read data
module mss_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] ram_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= ram_q[raddr];
	end
endmodule

### rtl/mss_sorter.sv
// Selection sort sequencer over the sample store, up to the median position
module mss_sorter #(
	parameter int AW = 10,
	parameter int CW = 11,
	parameter int DW = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mss_pkg::sort_ctl_t  ctl,
	input  logic [CW-1:0]       n,
	input  logic signed [DW-1:0] rdata,
	output logic [AW-1:0]       raddr,
	output logic                we,
	output logic [AW-1:0]       waddr,
	output logic [DW-1:0]       wdata,
	output logic                done,
	output logic signed [DW:0]  median
);
	import mss_pkg::*;

	sort_state_t          state_q, state_d;
	logic [CW-1:0]        n_q;
	logic [AW-1:0]        j_q;
	logic [CW-1:0]        ra_q;
	logic                 rd_s1;
	logic                 head_s1;
	logic [AW-1:0]        idx_s1;
	logic signed [DW-1:0] lowest_q;
	logic [AW-1:0]        best_q;
	logic signed [DW-1:0] headv_q;
	logic signed [DW-1:0] lo_q;
	logic signed [DW-1:0] hi_q;
	logic                 issue;
	logic [CW-1:0]        half;
	logic                 at_half;
	logic                 at_lo;

	assign half    = n_q >> 1;
	assign at_half = CW'(j_q) == half;
	assign at_lo   = !n_q[0] && (CW'(j_q) + CW'(1) == half);

	assign raddr  = (state_q == SORT_HEAD) ? j_q : ra_q[AW-1:0];
	assign waddr  = best_q;
	assign wdata  = headv_q;
	assign median = n_q[0] ? {hi_q, 1'b0} : ({lo_q[DW-1], lo_q} + {hi_q[DW-1], hi_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SORT_IDLE;
			rd_s1   <= 1'b0;
			head_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= issue;
			head_s1 <= (state_q == SORT_HEAD);
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		we      = 1'b0;
		done    = 1'b0;
		case (state_q)
			SORT_IDLE: begin
				if (ctl.start) begin
					state_d = SORT_HEAD;
				end
			end
			SORT_HEAD: begin
				issue   = 1'b1;
				state_d = SORT_SCAN;
			end
			SORT_SCAN: begin
				issue = ra_q < n_q;
				// leave once the last read word has been compared
				if (!issue && !rd_s1) begin
					state_d = SORT_SWAP;
				end
			end
			SORT_SWAP: begin
				we      = 1'b1;
				state_d = at_half ? SORT_DONE : SORT_HEAD;
			end
			SORT_DONE: begin
				done = 1'b1;
				if (ctl.ack) begin
					state_d = SORT_IDLE;
				end
			end
			default: begin
				state_d = SORT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == SORT_IDLE && ctl.start) begin
			n_q <= n;
			j_q <= '0;
		end
		if (state_q == SORT_HEAD) begin
			ra_q   <= CW'(j_q) + CW'(1);
			idx_s1 <= j_q;
		end else if (state_q == SORT_SCAN && issue) begin
			ra_q   <= ra_q + CW'(1);
			idx_s1 <= ra_q[AW-1:0];
		end
		if (rd_s1) begin
			if (head_s1 || rdata < lowest_q) begin
				lowest_q <= rdata;
				best_q   <= idx_s1;
			end
			if (head_s1) begin
				headv_q <= rdata;
			end
		end
		// the pass minimum is the j-th smallest: keep the one or two middle values
		if (state_q == SORT_SWAP) begin
			if (at_lo) begin
				lo_q <= lowest_q;
			end
			if (at_half) begin
				hi_q <= lowest_q;
			end else begin
				j_q <= j_q + AW'(1);
			end
		end
	end
endmodule

### rtl/median_by_selection_sort_core.sv
// Sample words are taken back to back while the core is not busy with a set; a full store
// drops further words and flags it. After the last word, a selection sort runs passes 0..n/2,
// each reading the words from its head on and writing the head word over the pass minimum.
// n is the stored count; the sort is bound by the single store read port, one read per cycle.
// A waiting median word does not block loading of the next set.
// Reset clears the count, the overflow flag and all control; the store is not cleared.
module median_by_selection_sort_core #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	mss_in_if.sink    samples,
	mss_out_if.source medians
);
	import mss_pkg::*;

	localparam int DW = SAMPLE_BITS;
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic                 busy_q;
	logic                 start_q;
	logic [CW-1:0]        count_q;
	logic                 ovf_q;
	logic                 out_valid_q;
	logic signed [DW:0]   median_q;
	logic [CW-1:0]        count_out_q;
	logic                 ovf_out_q;

	logic                 in_take;
	logic                 room;
	logic                 ld_we;
	sort_ctl_t            ctl;
	logic                 srt_done;
	logic signed [DW:0]   srt_median;
	logic [AW-1:0]        srt_raddr;
	logic                 srt_we;
	logic [AW-1:0]        srt_waddr;
	logic [DW-1:0]        srt_wdata;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [DW-1:0]        mem_wdata;
	logic signed [DW-1:0] mem_rdata;

	assign samples.ready = !busy_q;
	assign in_take       = samples.valid && samples.ready;
	assign room          = count_q < CW'(MAX_SAMPLES);
	assign ld_we         = in_take && room;

	assign ctl.start = start_q;
	assign ctl.ack   = srt_done && (!out_valid_q || medians.ready);

	assign mem_we    = ld_we || srt_we;
	assign mem_waddr = ld_we ? count_q[AW-1:0] : srt_waddr;
	assign mem_wdata = ld_we ? samples.sample : srt_wdata;

	assign medians.valid        = out_valid_q;
	assign medians.median_x2    = median_q;
	assign medians.sample_count = count_out_q;
	assign medians.overflowed   = ovf_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_take && samples.last_sample;
			if (in_take) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (samples.last_sample) begin
					busy_q <= 1'b1;
				end
			end
			if (ctl.ack) begin
				busy_q      <= 1'b0;
				count_q     <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (medians.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ack) begin
			median_q    <= srt_median;
			count_out_q <= count_q;
			ovf_out_q   <= ovf_q;
		end
	end

	mss_mem #(
		.DEPTH(MAX_SAMPLES),
		.AW   (AW),
		.DW   (DW)
	) u_mss_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(srt_raddr),
		.rdata(mem_rdata)
	);

	mss_sorter #(
		.AW(AW),
		.CW(CW),
		.DW(DW)
	) u_mss_sorter (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.n     (count_q),
		.rdata (mem_rdata),
		.raddr (srt_raddr),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (srt_wdata),
		.done  (srt_done),
		.median(srt_median)
	);
endmodule

### rtl/mss_checker.sv
// Port-level checker for the median core and its bind to the top level
`include "median_by_selection_sort_core_macros.svh"

module mss_checker #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  in_last,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [SAMPLE_BITS:0]           out_median,
	input logic [$clog2(MAX_SAMPLES + 1)-1:0]    out_count,
	input logic                                  out_ovf
);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	`MSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`MSS_ASSERT_IMP(a_count_range, out_valid, out_count != '0 && out_count <= CW'(MAX_SAMPLES))
	`MSS_ASSERT_IMP(a_odd_even_median, out_valid && out_count[0], !out_median[0])
	`MSS_ASSERT_IMP(a_ovf_full, out_valid && out_ovf, out_count == CW'(MAX_SAMPLES))
	`MSS_ASSERT_NXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready)
endmodule

bind median_by_selection_sort_core mss_checker #(
	.MAX_SAMPLES(MAX_SAMPLES),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_mss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_last   (samples.last_sample),
	.out_valid (medians.valid),
	.out_ready (medians.ready),
	.out_median(medians.median_x2),
	.out_count (medians.sample_count),
	.out_ovf   (medians.overflowed)
);

### tb/tb_top.sv
// Self-checking testbench for the selection-sort median core
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_SAMPLES = 1024;
	localparam int SAMPLE_BITS = 24;
	localparam int HOLD_LEN    = 3000;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS:0] median_x2;
		logic [10:0]                 sample_count;
		logic                        overflowed;
	} median_word_t;

	localparam sample_t SAMPLE_MAX = 24'h7FFFFF;
	localparam sample_t SAMPLE_MIN = 24'h800000;

	logic clk;
	logic arst_n;

	mss_in_if #(.DW(SAMPLE_BITS)) samples_if ();
	mss_out_if #(.DW(SAMPLE_BITS), .CW(11)) medians_if ();

	median_by_selection_sort_core #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.medians(medians_if)
	);

	// predictor state: the set being loaded
	sample_t      kept_samples [MAX_SAMPLES];
	int unsigned  kept_count = 0;
	logic         kept_full = 1'b0;
	median_word_t median_expected [$];

	int send_gap_pct = 0;
	int drain_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_cycles = 0;
	int fault_count = 0;
	int checked_words = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report_mismatch(input string msg);
		$display("median word %0d: %s", checked_words, msg);
		fault_count++;
	endtask

	// append one sample word; on the last word sort the set and queue its median
	function automatic void absorb_sample(sample_t s, logic is_last);
		int unsigned  j, i, pick, n;
		sample_t      lowest;
		median_word_t w;
		if (kept_count < MAX_SAMPLES) begin
			kept_samples[kept_count] = s;
			kept_count++;
		end else begin
			kept_full = 1'b1;
		end
		if (!is_last)
			return;
		n = kept_count;
		for (j = 0; j + 1 < n; j++) begin
			pick = j;
			lowest = kept_samples[j];
			for (i = j + 1; i < n; i++) begin
				if (kept_samples[i] < lowest) begin
					lowest = kept_samples[i];
					pick = i;
				end
			end
			kept_samples[pick] = kept_samples[j];
			kept_samples[j] = lowest;
		end
		if (n % 2 == 0)
			w.median_x2 = kept_samples[n/2 - 1] + kept_samples[n/2];
		else
			w.median_x2 = 2 * kept_samples[n/2];
		w.sample_count = 11'(n);
		w.overflowed = kept_full;
		median_expected.push_back(w);
		kept_count = 0;
		kept_full = 1'b0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && samples_if.valid && samples_if.ready)
			absorb_sample(samples_if.sample, samples_if.last_sample);
	end

	always @(posedge clk) begin
		median_word_t want;
		if (arst_n && medians_if.valid && medians_if.ready) begin
			if (median_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected word, median_x2 %0d count %0d",
					$signed(medians_if.median_x2), medians_if.sample_count));
			end else begin
				want = median_expected.pop_front();
				if (medians_if.median_x2 !== want.median_x2)
					report_mismatch($sformatf("median_x2 is %0d, expected %0d",
						$signed(medians_if.median_x2), $signed(want.median_x2)));
				if (medians_if.sample_count !== want.sample_count)
					report_mismatch($sformatf("sample_count is %0d, expected %0d",
						medians_if.sample_count, want.sample_count));
				if (medians_if.overflowed !== want.overflowed)
					report_mismatch($sformatf("overflowed is %0b, expected %0b",
						medians_if.overflowed, want.overflowed));
			end
			checked_words++;
		end
	end

	// receiver: a long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_cycles <= HOLD_LEN;
			medians_if.ready <= 1'b0;
		end else if (hold_cycles != 0) begin
			medians_if.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			medians_if.ready <= ($urandom_range(99) >= drain_stall_pct);
		end
	end

	task automatic send_word(input sample_t s, input logic is_last);
		while ($urandom_range(99) < send_gap_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= s;
		samples_if.last_sample <= is_last;
		do
			@(posedge clk);
		while (!(samples_if.valid && samples_if.ready));
	endtask

	task automatic drain_medians();
		samples_if.valid <= 1'b0;
		while (median_expected.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	function automatic sample_t random_sample();
		sample_t v;
		case ($urandom_range(3))
			0, 1: v = sample_t'($urandom());
			2: v = sample_t'(int'($urandom_range(8)) - 4);
			default: begin
				case ($urandom_range(3))
					0: v = SAMPLE_MAX;
					1: v = SAMPLE_MIN;
					2: v = '1;
					default: v = '0;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic int pick_set_size();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 12);
		else if (r < 95)
			return $urandom_range(13, 48);
		return $urandom_range(49, 128);
	endfunction

	task automatic test_single_word_sets();
		send_word(SAMPLE_MAX, 1'b1);
		send_word(SAMPLE_MIN, 1'b1);
		send_word('0, 1'b1);
		drain_medians();
	endtask

	// even counts: the two middle words are summed, extremes included
	task automatic test_even_pairs();
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MAX, 1'b1);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		send_word('0, 1'b0);
		send_word('1, 1'b1);
		drain_medians();
	endtask

	task automatic test_unsorted_and_ties();
		send_word(sample_t'(50), 1'b0);
		send_word(sample_t'(40), 1'b0);
		send_word(sample_t'(-30), 1'b0);
		send_word(sample_t'(20), 1'b0);
		send_word(sample_t'(-10), 1'b1);
		send_word(sample_t'(7), 1'b0);
		send_word(sample_t'(-3), 1'b0);
		send_word(sample_t'(7), 1'b0);
		send_word(sample_t'(-3), 1'b1);
		drain_medians();
	endtask

	// fill the store, then drop three more words, the last word among them
	task automatic test_store_full();
		for (int k = 0; k < MAX_SAMPLES; k++)
			send_word(random_sample(), 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word('1, 1'b1);
		drain_medians();
	endtask

	// hold the median port off so finished sets pile up and the input stalls
	task automatic test_backpressure();
		send_gap_pct = 0;
		drain_stall_pct = 0;
		hold_requests++;
		for (int k = 0; k < 10; k++) begin
			send_word(random_sample(), 1'b0);
			send_word(random_sample(), 1'b0);
			send_word(random_sample(), 1'b1);
		end
		drain_medians();
	endtask

	task automatic test_random_sets(input int words, input int gap_pct, input int stall_pct);
		int sent;
		int n;
		send_gap_pct = gap_pct;
		drain_stall_pct = stall_pct;
		sent = 0;
		while (sent < words) begin
			n = pick_set_size();
			if (n > words - sent)
				n = words - sent;
			for (int k = 0; k < n; k++)
				send_word(random_sample(), k == n - 1);
			sent += n;
		end
		drain_medians();
	endtask

	initial begin
		arst_n <= 1'b0;
		samples_if.valid <= 1'b0;
		samples_if.sample <= '0;
		samples_if.last_sample <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_word_sets();
		test_even_pairs();
		test_unsorted_and_ties();
		test_store_full();
		test_backpressure();
		test_random_sets(23, 0, 0);
		test_random_sets(23, 47, 0);
		test_random_sets(23, 0, 47);
		test_random_sets(24, 29, 29);

		if (fault_count == 0)
			$display("median_by_selection_sort_core: match");
		else
			$display("median_by_selection_sort_core: mismatch");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("median_by_selection_sort_core: mismatch");
		$finish;
	end

endmodule
